// ----- hdl/mecodo_pkg.sv -----
// ----------------------------------------------------------------------------
// mecodo_pkg: shared types and constants of the mecanum odometry integrator
// Word layouts, arithmetic widths, the arctangent table and rounding helpers.
// ----------------------------------------------------------------------------
package mecodo_pkg;

   localparam int TRIG_ITERATIONS = 16;
   localparam int TRIG_STEPS      = (TRIG_ITERATIONS < 32) ? TRIG_ITERATIONS : 32;

   localparam int SUM_W  = 34;
   localparam int TRIG_W = 34;
   localparam int A_W    = 36;
   localparam int B_W    = TRIG_W;
   localparam int PW     = A_W + B_W;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic signed [TRIG_W-1:0] CORDIC_START    = TRIG_W'(652032874);
   localparam logic signed [B_W-1:0]    TURN_PER_RADIAN = B_W'(683565276);
   localparam logic signed [PW-1:0]     TURN_HALF       = PW'(1) <<< 31;
   localparam logic signed [PW-1:0]     SAT_HI          = (PW'(1) <<< 31) - PW'(1);
   localparam logic signed [PW-1:0]     SAT_LO          = -(PW'(1) <<< 31);

   localparam int WHEEL_SHIFT = 18;
   localparam int FRAC_SHIFT  = 16;
   localparam int TRIG_SHIFT  = 30;

   localparam logic REG_RADIUS = 1'b0;
   localparam logic REG_RECIP  = 1'b1;

   typedef struct packed {
      logic signed [31:0] speed_front_left;
      logic signed [31:0] speed_front_right;
      logic signed [31:0] speed_back_left;
      logic signed [31:0] speed_back_right;
      logic [15:0]        tick_period;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pose_x;
      logic signed [31:0] pose_y;
      logic [31:0]        pose_heading;
      logic signed [31:0] body_vx;
      logic signed [31:0] body_vy;
      logic signed [31:0] body_yaw_rate;
   } rsp_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] sum_x;
      logic signed [SUM_W-1:0] sum_y;
      logic signed [SUM_W-1:0] sum_w;
      logic [15:0]             period;
   } entry_type;

   function automatic logic signed [TRIG_W-1:0] atan_turn(input logic [4:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0:  v = 32'h20000000;
         5'd1:  v = 32'h12E4051D;
         5'd2:  v = 32'h09FB385B;
         5'd3:  v = 32'h051111D4;
         5'd4:  v = 32'h028B0D43;
         5'd5:  v = 32'h0145D7E1;
         5'd6:  v = 32'h00A2F61E;
         5'd7:  v = 32'h00517C55;
         5'd8:  v = 32'h0028BE53;
         5'd9:  v = 32'h00145F2E;
         5'd10: v = 32'h000A2F98;
         5'd11: v = 32'h000517CC;
         5'd12: v = 32'h00028BE6;
         5'd13: v = 32'h000145F3;
         5'd14: v = 32'h0000A2F9;
         5'd15: v = 32'h0000517C;
         5'd16: v = 32'h000028BE;
         5'd17: v = 32'h0000145F;
         5'd18: v = 32'h00000A2F;
         5'd19: v = 32'h00000517;
         5'd20: v = 32'h0000028B;
         5'd21: v = 32'h00000145;
         5'd22: v = 32'h000000A2;
         5'd23: v = 32'h00000051;
         5'd24: v = 32'h00000028;
         5'd25: v = 32'h00000014;
         5'd26: v = 32'h0000000A;
         5'd27: v = 32'h00000005;
         5'd28: v = 32'h00000002;
         5'd29: v = 32'h00000001;
         default: v = 32'h00000000;
      endcase
      return $signed({{(TRIG_W-32){1'b0}}, v});
   endfunction

   function automatic logic signed [PW-1:0] rnd_shift(input logic signed [PW-1:0] v,
                                                      input int unsigned n);
      logic signed [PW-1:0] half;
      half = PW'(1) <<< (n - 1);
      return (v + half) >>> n;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] v);
      logic signed [PW-1:0] s;
      if (v > SAT_HI) s = SAT_HI;
      else if (v < SAT_LO) s = SAT_LO;
      else s = v;
      return s[31:0];
   endfunction

endpackage

// ----- hdl/mecodo_front.sv -----
// ----------------------------------------------------------------------------
// mecodo_front: input side
// Takes tick words and forms the three wheel combinations for the queue.
// ----------------------------------------------------------------------------
module mecodo_front (
   input  logic                  req_valid,
   output logic                  req_ready,
   input  mecodo_pkg::req_type   req_payload,
   input  logic                  q_full,
   output logic                  q_push,
   output mecodo_pkg::entry_type q_data
);

   logic signed [mecodo_pkg::SUM_W-1:0] fl, fr, bl, br;

   assign fl = mecodo_pkg::SUM_W'(req_payload.speed_front_left);
   assign fr = mecodo_pkg::SUM_W'(req_payload.speed_front_right);
   assign bl = mecodo_pkg::SUM_W'(req_payload.speed_back_left);
   assign br = mecodo_pkg::SUM_W'(req_payload.speed_back_right);

   assign req_ready     = ~q_full;
   assign q_push        = req_valid & ~q_full;
   assign q_data.sum_x  = fl + fr + bl + br;
   assign q_data.sum_y  = fr + bl - fl - br;
   assign q_data.sum_w  = fr + br - fl - bl;
   assign q_data.period = req_payload.tick_period;

endmodule

// ----- hdl/mecodo_queue.sv -----
// ----------------------------------------------------------------------------
// mecodo_queue: short queue between front and back
// Holds classified ticks so each side stalls on its own.
// ----------------------------------------------------------------------------
module mecodo_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  mecodo_pkg::entry_type push_data,
   output logic                  full,
   input  logic                  pop,
   output mecodo_pkg::entry_type pop_data,
   output logic                  empty
);

   mecodo_pkg::entry_type mem_ff [mecodo_pkg::QUEUE_DEPTH];
   logic [mecodo_pkg::QPTR_W-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [mecodo_pkg::QCNT_W-1:0] cnt_ff, cnt_in;

   localparam logic [mecodo_pkg::QPTR_W-1:0] PTR_LAST =
      mecodo_pkg::QPTR_W'(mecodo_pkg::QUEUE_DEPTH - 1);

   assign full     = (cnt_ff == mecodo_pkg::QCNT_W'(mecodo_pkg::QUEUE_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_data = mem_ff[rptr_ff];

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      cnt_in  = cnt_ff;
      if (push) begin
         wptr_in = (wptr_ff == PTR_LAST) ? '0 : wptr_ff + 1'b1;
      end
      if (pop) begin
         rptr_in = (rptr_ff == PTR_LAST) ? '0 : rptr_ff + 1'b1;
      end
      if (push && !pop) cnt_in = cnt_ff + 1'b1;
      else if (pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= push_data;
      end
   end

endmodule

// ----- hdl/mecodo_trig.sv -----
// ----------------------------------------------------------------------------
// mecodo_trig: iterative sine and cosine of a binary angle
// One rotation step per cycle after a half-turn fold.
// ----------------------------------------------------------------------------
module mecodo_trig (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [31:0]                         angle,
   output logic                                trig_valid,
   output logic signed [mecodo_pkg::TRIG_W-1:0] cos_out,
   output logic signed [mecodo_pkg::TRIG_W-1:0] sin_out
);

   localparam logic [4:0] LAST_STEP = 5'(mecodo_pkg::TRIG_STEPS - 1);

   logic                                busy_ff, busy_in, valid_ff, valid_in;
   logic                                flip_ff, flip_in;
   logic [4:0]                          idx_ff, idx_in;
   logic signed [mecodo_pkg::TRIG_W-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic signed [mecodo_pkg::TRIG_W-1:0] xs, ys, at;
   logic [31:0]                         folded;

   assign xs     = x_ff >>> idx_ff;
   assign ys     = y_ff >>> idx_ff;
   assign at     = mecodo_pkg::atan_turn(idx_ff);
   assign folded = (angle[31] ^ angle[30]) ? {~angle[31], angle[30:0]} : angle;

   always_comb begin
      busy_in  = busy_ff;
      valid_in = valid_ff;
      flip_in  = flip_ff;
      idx_in   = idx_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      if (start) begin
         busy_in  = 1'b1;
         valid_in = 1'b0;
         flip_in  = angle[31] ^ angle[30];
         idx_in   = '0;
         x_in     = mecodo_pkg::CORDIC_START;
         y_in     = '0;
         z_in     = mecodo_pkg::TRIG_W'($signed(folded));
      end else if (busy_ff) begin
         if (z_ff >= 0) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + at;
         end
         if (idx_ff == LAST_STEP) begin
            busy_in  = 1'b0;
            valid_in = 1'b1;
         end else begin
            idx_in = idx_ff + 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      flip_ff <= flip_in;
      idx_ff  <= idx_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
   end

   assign trig_valid = valid_ff;
   assign cos_out    = flip_ff ? -x_ff : x_ff;
   assign sin_out    = flip_ff ? -y_ff : y_ff;

endmodule

// ----- hdl/mecodo_back.sv -----
// ----------------------------------------------------------------------------
// mecodo_back: kinematics, rotation and pose integration
// A sequencer over one shared multiplier, the trig unit and the result word.
// ----------------------------------------------------------------------------
module mecodo_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [15:0]           radius,
   input  logic [23:0]           recip,
   input  logic                  q_empty,
   input  mecodo_pkg::entry_type q_data,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output mecodo_pkg::rsp_type   rsp_payload
);

   localparam int PW  = mecodo_pkg::PW;
   localparam int A_W = mecodo_pkg::A_W;
   localparam int B_W = mecodo_pkg::B_W;

   typedef enum logic [2:0] {
      B_IDLE = 3'b001,
      B_RUN  = 3'b010,
      B_DONE = 3'b100
   } state_type;

   typedef enum logic [3:0] {
      ST_VX, ST_VY, ST_TW, ST_YAW, ST_VXC, ST_VYS, ST_VXS, ST_VYC,
      ST_WXT, ST_WYT, ST_YT, ST_PHI, ST_FRC
   } step_type;

   state_type             st_ff, st_in;
   step_type              step_ff, step_in;
   logic                  phase_ff, phase_in;
   mecodo_pkg::entry_type ent_ff, ent_in;
   logic signed [31:0]    vx_ff, vx_in, vy_ff, vy_in, yaw_ff, yaw_in;
   logic signed [32:0]    tw_ff, tw_in, phi_ff, phi_in;
   logic signed [34:0]    wx_ff, wx_in, wy_ff, wy_in;
   logic [15:0]           frac_ff, frac_in;
   logic signed [PW-1:0]  acc_ff, acc_in, prod_ff, prod_in;
   logic signed [31:0]    posx_ff, posx_in, posy_ff, posy_in;
   logic [31:0]           head_ff, head_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   mecodo_pkg::rsp_type   rsp_ff, rsp_in;

   logic                               trig_start, trig_valid;
   logic signed [mecodo_pkg::TRIG_W-1:0] cos_v, sin_v;
   logic signed [A_W-1:0]              mul_a;
   logic signed [B_W-1:0]              mul_b, b_radius, b_recip, b_dt;
   logic signed [PW-1:0]               rnd18, rnd16, wx_sum, wy_sum;
   logic signed [PW-1:0]               posx_sum, posy_sum, phi_full, dth_inner;

   mecodo_trig u_trig (
      .clock      (clock),
      .reset      (reset),
      .start      (trig_start),
      .angle      (head_ff),
      .trig_valid (trig_valid),
      .cos_out    (cos_v),
      .sin_out    (sin_v)
   );

   assign b_radius = B_W'($signed({1'b0, radius}));
   assign b_recip  = B_W'($signed({1'b0, recip}));
   assign b_dt     = B_W'($signed({1'b0, ent_ff.period}));

   always_comb begin
      case (step_ff)
         ST_VX:  begin mul_a = A_W'(ent_ff.sum_x); mul_b = b_radius; end
         ST_VY:  begin mul_a = A_W'(ent_ff.sum_y); mul_b = b_radius; end
         ST_TW:  begin mul_a = A_W'(ent_ff.sum_w); mul_b = b_radius; end
         ST_YAW: begin mul_a = A_W'(tw_ff);  mul_b = b_recip; end
         ST_VXC: begin mul_a = A_W'(vx_ff);  mul_b = cos_v; end
         ST_VYS: begin mul_a = A_W'(vy_ff);  mul_b = sin_v; end
         ST_VXS: begin mul_a = A_W'(vx_ff);  mul_b = sin_v; end
         ST_VYC: begin mul_a = A_W'(vy_ff);  mul_b = cos_v; end
         ST_WXT: begin mul_a = A_W'(wx_ff);  mul_b = b_dt; end
         ST_WYT: begin mul_a = A_W'(wy_ff);  mul_b = b_dt; end
         ST_YT:  begin mul_a = A_W'(yaw_ff); mul_b = b_dt; end
         ST_PHI: begin mul_a = A_W'(phi_ff); mul_b = mecodo_pkg::TURN_PER_RADIAN; end
         ST_FRC: begin
            mul_a = A_W'($signed({1'b0, frac_ff}));
            mul_b = mecodo_pkg::TURN_PER_RADIAN;
         end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   assign prod_in   = mul_a * mul_b;
   assign rnd18     = mecodo_pkg::rnd_shift(prod_ff, mecodo_pkg::WHEEL_SHIFT);
   assign rnd16     = mecodo_pkg::rnd_shift(prod_ff, mecodo_pkg::FRAC_SHIFT);
   assign wx_sum    = mecodo_pkg::rnd_shift(acc_ff - prod_ff, mecodo_pkg::TRIG_SHIFT);
   assign wy_sum    = mecodo_pkg::rnd_shift(acc_ff + prod_ff, mecodo_pkg::TRIG_SHIFT);
   assign posx_sum  = PW'(posx_ff) + rnd16;
   assign posy_sum  = PW'(posy_ff) + rnd16;
   assign phi_full  = prod_ff >>> mecodo_pkg::FRAC_SHIFT;
   assign dth_inner = acc_ff + ((prod_ff + mecodo_pkg::TURN_HALF) >>> mecodo_pkg::FRAC_SHIFT);

   always_comb begin
      st_in        = st_ff;
      step_in      = step_ff;
      phase_in     = phase_ff;
      ent_in       = ent_ff;
      vx_in        = vx_ff;
      vy_in        = vy_ff;
      tw_in        = tw_ff;
      yaw_in       = yaw_ff;
      acc_in       = acc_ff;
      wx_in        = wx_ff;
      wy_in        = wy_ff;
      phi_in       = phi_ff;
      frac_in      = frac_ff;
      posx_in      = posx_ff;
      posy_in      = posy_ff;
      head_in      = head_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_in       = rsp_ff;
      q_pop        = 1'b0;
      trig_start   = 1'b0;
      unique case (st_ff)
         B_IDLE: begin
            if (!q_empty) begin
               q_pop      = 1'b1;
               trig_start = 1'b1;
               ent_in     = q_data;
               step_in    = ST_VX;
               phase_in   = 1'b0;
               st_in      = B_RUN;
            end
         end
         B_RUN: begin
            if (!phase_ff) begin
               if (step_ff != ST_VXC || trig_valid) phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               case (step_ff)
                  ST_VX:  vx_in   = mecodo_pkg::sat32(rnd18);
                  ST_VY:  vy_in   = mecodo_pkg::sat32(rnd18);
                  ST_TW:  tw_in   = rnd18[32:0];
                  ST_YAW: yaw_in  = mecodo_pkg::sat32(rnd16);
                  ST_VXC: acc_in  = prod_ff;
                  ST_VYS: wx_in   = wx_sum[34:0];
                  ST_VXS: acc_in  = prod_ff;
                  ST_VYC: wy_in   = wy_sum[34:0];
                  ST_WXT: posx_in = mecodo_pkg::sat32(posx_sum);
                  ST_WYT: posy_in = mecodo_pkg::sat32(posy_sum);
                  ST_YT: begin
                     phi_in  = phi_full[32:0];
                     frac_in = prod_ff[15:0];
                  end
                  ST_PHI: acc_in  = prod_ff;
                  ST_FRC: head_in = head_ff + dth_inner[47:16];
                  default: ;
               endcase
               if (step_ff == ST_FRC) st_in = B_DONE;
               else step_in = step_type'(step_ff + 4'd1);
            end
         end
         B_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in         = 1'b1;
               rsp_in.pose_x        = posx_ff;
               rsp_in.pose_y        = posy_ff;
               rsp_in.pose_heading  = head_ff;
               rsp_in.body_vx       = vx_ff;
               rsp_in.body_vy       = vy_ff;
               rsp_in.body_yaw_rate = yaw_ff;
               st_in                = B_IDLE;
            end
         end
         default: st_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= B_IDLE;
         phase_ff     <= 1'b0;
         step_ff      <= ST_VX;
         rsp_valid_ff <= 1'b0;
         posx_ff      <= '0;
         posy_ff      <= '0;
         head_ff      <= '0;
      end else begin
         st_ff        <= st_in;
         phase_ff     <= phase_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         posx_ff      <= posx_in;
         posy_ff      <= posy_in;
         head_ff      <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff  <= ent_in;
      vx_ff   <= vx_in;
      vy_ff   <= vy_in;
      tw_ff   <= tw_in;
      yaw_ff  <= yaw_in;
      acc_ff  <= acc_in;
      wx_ff   <= wx_in;
      wy_ff   <= wy_in;
      phi_ff  <= phi_in;
      frac_ff <= frac_in;
      prod_ff <= prod_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // rotation must never consume a stale sine or cosine
   a_trig_ready: assert property (@(posedge clock) disable iff (reset)
      (st_ff == B_RUN && phase_ff && step_ff == ST_VXC) |-> trig_valid)
      else $error("rotation step without trig result");

   a_head_hold: assert property (@(posedge clock) disable iff (reset)
      (st_ff != B_RUN) |=> $stable(head_ff))
      else $error("heading moved outside the sequence");

   a_done_load: assert property (@(posedge clock) disable iff (reset)
      (st_ff == B_DONE && (!rsp_valid_ff || rsp_ready)) |=> (rsp_valid_ff && st_ff == B_IDLE))
      else $error("result word not loaded");

endmodule

// ----- hdl/mecanum_odometry_integrator_top.sv -----
// ----------------------------------------------------------------------------
// mecanum_odometry_integrator_top: mecanum wheel odometry integrator
// Forward kinematics, heading rotation and saturating pose integration.
// ----------------------------------------------------------------------------
// Usage:
//   req_* takes one word per control tick: four wheel speeds and the period.
//   rsp_* returns one word per tick: pose after the tick and body velocity.
//   psel/penable/pwrite/paddr/pwdata set wheel radius (0x0) and reciprocal
//   arm sum (0x4); write only while the block is idle.
// Sequence:
//   With the back end free, an accepted tick is popped and the sine/cosine
//   unit started; 16 rotation steps follow with the four kinematics products
//   running beneath them, then nine products run on the shared multiplier,
//   and then the result word is loaded. The back end finishes each word
//   before it pops the next.
//   A two-word queue takes new ticks while one is being worked.
// Reset clears pose, heading, configuration and all valid state.
// When rsp_ready is low the result word holds; the back end waits with the
// next finished word and the queue keeps accepting until full.
// ----------------------------------------------------------------------------
module mecanum_odometry_integrator_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  mecodo_pkg::req_type req_payload,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output mecodo_pkg::rsp_type rsp_payload,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [2:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

   logic [15:0]           radius_ff, radius_in;
   logic [23:0]           recip_ff, recip_in;
   logic                  csr_index;
   logic                  q_full, q_push, q_pop, q_empty;
   mecodo_pkg::entry_type q_wdata, q_rdata;

   assign pready    = 1'b1;
   assign csr_index = paddr[2];

   always_comb begin
      radius_in = radius_ff;
      recip_in  = recip_ff;
      if (psel && penable && pwrite) begin
         unique case (csr_index)
            mecodo_pkg::REG_RADIUS: radius_in = pwdata[15:0];
            mecodo_pkg::REG_RECIP:  recip_in  = pwdata[23:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         mecodo_pkg::REG_RADIUS: prdata = {16'd0, radius_ff};
         mecodo_pkg::REG_RECIP:  prdata = {8'd0, recip_ff};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= '0;
         recip_ff  <= '0;
      end else begin
         radius_ff <= radius_in;
         recip_ff  <= recip_in;
      end
   end

   mecodo_front u_front (
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_data      (q_wdata)
   );

   mecodo_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .empty     (q_empty)
   );

   mecodo_back u_back (
      .clock       (clock),
      .reset       (reset),
      .radius      (radius_ff),
      .recip       (recip_ff),
      .q_empty     (q_empty),
      .q_data      (q_rdata),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// ----- bench/mecanum_odometry_integrator_top_tb.sv -----
// ----------------------------------------------------------------------------
// mecanum_odometry_integrator_top_tb: self-checking bench for the odometry block
// A directed table of extreme ticks is followed by random ticks under several
// radius/arm settings. Each accepted word is predicted by a bit-exact model of
// the kinematics, CORDIC rotation and pose integration, and each result word
// is compared field by field. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module mecanum_odometry_integrator_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 64;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   mecodo_pkg::req_type req_payload = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   mecodo_pkg::rsp_type rsp_payload;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [2:0]          paddr = '0;
   logic [31:0]         pwdata = '0;
   logic [31:0]         prdata;
   logic                pready;

   mecanum_odometry_integrator_top i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   typedef struct {
      mecodo_pkg::req_type tick;
      bit                  typed;
   } table_row_type;

   // model state
   logic [15:0] radius_q;
   logic [23:0] arm_recip_q;
   longint      pos_x_q;
   longint      pos_y_q;
   logic [31:0] heading_q;

   mecodo_pkg::rsp_type pose_queue[$];
   table_row_type       directed[$];
   int                  errors = 0;
   int                  quiet_cycles = 0;
   bit                  no_idle = 1'b0;

   const longint ATAN_TURNS[32] = '{
      64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
      64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2E,
      64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
      64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
      64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051, 64'h00000028,
      64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000002, 64'h00000001,
      64'h0, 64'h0};

   function automatic longint round_shift(longint v, int n);
      return (v + (64'sd1 <<< (n - 1))) >>> n;
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic void sin_cos(logic [31:0] ang, output longint c, output longint s);
      logic        flip;
      logic [31:0] a;
      longint      x, y, z, xs, ys;
      flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
      a = flip ? (ang ^ 32'h80000000) : ang;
      z = longint'($signed(a));
      x = 652032874;
      y = 0;
      for (int i = 0; i < mecodo_pkg::TRIG_STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x -= ys; y += xs; z -= ATAN_TURNS[i];
         end else begin
            x += ys; y -= xs; z += ATAN_TURNS[i];
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic mecodo_pkg::rsp_type integrate_tick(mecodo_pkg::req_type t);
      longint  fl, fr, bl, br, dt, r, vx, vy, tw, yaw, c, s, wx, wy, p, phi, inner, dth;
      mecodo_pkg::rsp_type o;
      fl = longint'(t.speed_front_left);
      fr = longint'(t.speed_front_right);
      bl = longint'(t.speed_back_left);
      br = longint'(t.speed_back_right);
      dt = longint'({48'b0, t.tick_period});
      r  = longint'({48'b0, radius_q});
      vx = clamp32(round_shift((fl + fr + bl + br) * r, mecodo_pkg::WHEEL_SHIFT));
      vy = clamp32(round_shift((-fl + fr + bl - br) * r, mecodo_pkg::WHEEL_SHIFT));
      tw = round_shift((-fl + fr - bl + br) * r, mecodo_pkg::WHEEL_SHIFT);
      yaw = clamp32(round_shift(tw * longint'({40'b0, arm_recip_q}),
                                mecodo_pkg::FRAC_SHIFT));
      sin_cos(heading_q, c, s);
      wx = round_shift(vx * c - vy * s, mecodo_pkg::TRIG_SHIFT);
      wy = round_shift(vx * s + vy * c, mecodo_pkg::TRIG_SHIFT);
      pos_x_q = clamp32(pos_x_q + round_shift(wx * dt, mecodo_pkg::FRAC_SHIFT));
      pos_y_q = clamp32(pos_y_q + round_shift(wy * dt, mecodo_pkg::FRAC_SHIFT));
      p = yaw * dt;
      phi = p >>> 16;
      inner = phi * 64'sd683565276 +
              (((p & 64'hFFFF) * 64'sd683565276 + 64'sh80000000) >>> 16);
      dth = inner >>> 16;
      heading_q = heading_q + dth[31:0];
      o.pose_x = pos_x_q[31:0];
      o.pose_y = pos_y_q[31:0];
      o.pose_heading = heading_q;
      o.body_vx = vx[31:0];
      o.body_vy = vy[31:0];
      o.body_yaw_rate = yaw[31:0];
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic int pick_gap();
      int k;
      if (no_idle) return 0;
      k = $urandom_range(99);
      if (k < 60) return 0;
      if (k < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic void add_row(mecodo_pkg::req_type tick, bit typed);
      table_row_type row;
      row.tick = tick;
      row.typed = typed;
      directed.insert(directed.size(), row);
   endfunction

   // result side
   always @(negedge clock) begin
      if (!reset)
         rsp_ready <= (no_idle || $urandom_range(99) < 70) ? 1'b1 : 1'b0;
   end

   always @(posedge clock) begin
      mecodo_pkg::rsp_type want;
      if (rsp_valid && rsp_ready && !reset) begin
         if (pose_queue.size() == 0) begin
            report_mismatch("unexpected word", rsp_payload.pose_x, 32'h0);
         end else begin
            want = pose_queue.pop_front();
            if (rsp_payload.pose_x !== want.pose_x)
               report_mismatch("pose_x", rsp_payload.pose_x, want.pose_x);
            if (rsp_payload.pose_y !== want.pose_y)
               report_mismatch("pose_y", rsp_payload.pose_y, want.pose_y);
            if (rsp_payload.pose_heading !== want.pose_heading)
               report_mismatch("pose_heading", rsp_payload.pose_heading, want.pose_heading);
            if (rsp_payload.body_vx !== want.body_vx)
               report_mismatch("body_vx", rsp_payload.body_vx, want.body_vx);
            if (rsp_payload.body_vy !== want.body_vy)
               report_mismatch("body_vy", rsp_payload.body_vy, want.body_vy);
            if (rsp_payload.body_yaw_rate !== want.body_yaw_rate)
               report_mismatch("body_yaw_rate", rsp_payload.body_yaw_rate,
                               want.body_yaw_rate);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("mecanum_odometry_integrator_top_tb NOT OK");
         $finish;
      end
   end

   // called at a falling edge; returns at a falling edge
   task automatic send_tick(mecodo_pkg::req_type t, bit typed,
                            mecodo_pkg::rsp_type typed_want);
      int                  gap;
      mecodo_pkg::rsp_type pred;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_payload <= t;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      pred = integrate_tick(t);
      pose_queue.insert(pose_queue.size(), typed ? typed_want : pred);
      @(negedge clock);
   endtask

   task automatic write_reg(logic reg_sel, logic [31:0] value);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= {reg_sel, 2'b00}; pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (reg_sel == mecodo_pkg::REG_RADIUS) radius_q = value[15:0];
      else arm_recip_q = value[23:0];
      @(negedge clock);
      pwrite <= 1'b0; penable <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== (reg_sel == mecodo_pkg::REG_RADIUS ? {16'b0, radius_q}
                                                        : {8'b0, arm_recip_q}))
         report_mismatch("register readback", prdata,
                         reg_sel == mecodo_pkg::REG_RADIUS ? {16'b0, radius_q}
                                                           : {8'b0, arm_recip_q});
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pose_queue.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic logic [31:0] rand_speed();
      int k;
      k = $urandom_range(99);
      if (k < 40) return $urandom();
      if (k < 80) return 32'($signed($urandom_range(0, 32'h1FFFFF)) - 32'sh100000);
      if (k < 90) return ($urandom_range(1)) ? 32'h7FFFFFFF : 32'h80000000;
      return 32'h0;
   endfunction

   function automatic mecodo_pkg::req_type mk_tick(logic [31:0] fl, logic [31:0] fr,
                                                   logic [31:0] bl, logic [31:0] br,
                                                   logic [15:0] dt);
      mecodo_pkg::req_type t;
      t.speed_front_left = fl;
      t.speed_front_right = fr;
      t.speed_back_left = bl;
      t.speed_back_right = br;
      t.tick_period = dt;
      return t;
   endfunction

   initial begin
      mecodo_pkg::req_type t;
      logic [31:0]         cfg_r[6];
      logic [31:0]         cfg_a[6];
      int                  k;

      radius_q = '0; arm_recip_q = '0;
      pos_x_q = 0; pos_y_q = 0; heading_q = '0;

      // zero radius after reset: every field reads zero
      add_row(mk_tick(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                      32'h7FFFFFFF, 16'hFFFF), 1'b1);
      add_row(mk_tick(32'h80000000, 32'h80000000, 32'h80000000,
                      32'h80000000, 16'hFFFF), 1'b1);
      add_row(mk_tick(32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                      32'h7FFFFFFF, 16'h0), 1'b1);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i]) send_tick(directed[i].tick, directed[i].typed, '0);
      drain();
      directed.delete();

      write_reg(mecodo_pkg::REG_RADIUS, 32'h0000FFFF);
      write_reg(mecodo_pkg::REG_RECIP, 32'h00FFFFFF);
      add_row(mk_tick(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                      32'h7FFFFFFF, 16'h0), 1'b0);
      add_row(mk_tick(32'h80000000, 32'h80000000, 32'h80000000,
                      32'h80000000, 16'h0), 1'b0);
      add_row(mk_tick(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                      32'h80000000, 16'h1), 1'b0);
      add_row(mk_tick(32'hFFF00000, 32'h00100000, 32'hFFF00000,
                      32'h00100000, 16'hFFFF), 1'b0);
      add_row(mk_tick(32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                      32'h7FFFFFFF, 16'hFFFF), 1'b0);
      add_row(mk_tick(32'h00010000, 32'h00010000, 32'h00010000,
                      32'h00010000, 16'h8000), 1'b0);
      for (int i = 0; i < 8; i++)
         add_row(mk_tick(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                         32'h7FFFFFFF, 16'hFFFF), 1'b0);
      for (int i = 0; i < 6; i++)
         add_row(mk_tick(32'h80000000, 32'h80000000, 32'h80000000,
                         32'h80000000, 16'hFFFF), 1'b0);
      add_row(mk_tick(32'h0, 32'h0, 32'h0, 32'h0, 16'hFFFF), 1'b0);
      foreach (directed[i]) send_tick(directed[i].tick, 1'b0, '0);
      drain();

      cfg_r = '{32'h0000FFFF, 32'h0, 32'($urandom_range(65535)), 32'($urandom_range(1, 4096)),
                32'($urandom_range(65535)), 32'h1};
      cfg_a = '{32'h00FFFFFF, 32'($urandom_range(24'hFFFFFF)), 32'h0,
                32'($urandom_range(1, 300000)), 32'($urandom_range(24'hFFFFFF)), 32'h1};
      for (int ph = 0; ph < 6; ph++) begin
         write_reg(mecodo_pkg::REG_RADIUS, cfg_r[ph]);
         write_reg(mecodo_pkg::REG_RECIP, cfg_a[ph]);
         no_idle = (ph % 3 == 1);
         for (int n = 0; n < 240; n++) begin
            k = $urandom_range(99);
            t = mk_tick(rand_speed(), rand_speed(), rand_speed(), rand_speed(),
                        k < 50 ? 16'($urandom()) :
                        k < 80 ? 16'($urandom_range(1, 64)) :
                        k < 90 ? 16'h0 : 16'hFFFF);
            send_tick(t, 1'b0, '0);
         end
         no_idle = 1'b0;
         drain();
      end

      if (errors == 0)
         $display("mecanum_odometry_integrator_top_tb OK");
      else
         $display("mecanum_odometry_integrator_top_tb NOT OK");
      $finish;
   end

endmodule
